// ===== rtl/lsmt_pkg.sv =====
package lsmt_pkg;

	// Display modes as reported on the mode output.
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_LINE_COMPARE = 3'd0,
		REG_STAT_SELECT  = 3'd1,
		REG_WINDOW_ON    = 3'd2,
		REG_WINDOW_Y     = 3'd3,
		REG_WINDOW_X     = 3'd4
	} reg_index_t;

	localparam int unsigned DOTS_W   = 7;
	localparam int unsigned ACCUM_W  = 10;
	localparam int unsigned LINE_W   = 8;
	localparam int unsigned CFG_W    = 8;

	localparam logic [DOTS_W-1:0]  DOTS_MAX    = 7'd80;
	localparam logic [ACCUM_W-1:0] OAM_DOTS    = 10'd80;
	localparam logic [ACCUM_W-1:0] DRAW_DOTS   = 10'd172;
	localparam logic [ACCUM_W-1:0] HBLANK_DOTS = 10'd204;
	localparam logic [ACCUM_W-1:0] LINE_DOTS   = 10'd456;
	localparam logic [LINE_W-1:0]  VBLANK_LINE = 8'd144;
	localparam logic [LINE_W-1:0]  FRAME_LINES = 8'd154;
	localparam logic [LINE_W-1:0]  WINX_MAX    = 8'd166;

	// Status interrupt select bits.
	localparam int unsigned SEL_HBLANK = 0;
	localparam int unsigned SEL_VBLANK = 1;
	localparam int unsigned SEL_OAM    = 2;
	localparam int unsigned SEL_MATCH  = 3;

	typedef struct packed {
		logic [LINE_W-1:0] line_compare;
		logic [3:0]        stat_select;
		logic              window_on;
		logic [LINE_W-1:0] window_y;
		logic [LINE_W-1:0] window_x;
	} cfg_t;

	typedef struct packed {
		logic [ACCUM_W-1:0] dot_accum;
		mode_t              cur_mode;
		logic [LINE_W-1:0]  cur_line;
		logic [LINE_W-1:0]  win_line;
		logic               match_flag;
	} state_t;

	typedef struct packed {
		logic scan_start;
		logic draw_start;
		logic frame_ready;
		logic vblank_irq;
		logic status_irq;
	} pulse_t;

endpackage

// ===== rtl/lcd_scanline_mode_timer.sv =====
// LCD scanline mode timer.
// Input channel (in_valid/in_ready/dots): each request carries the number of
// dot clocks elapsed since the previous one; counts above 80 are taken as 80.
// Output channel (out_valid/out_ready and the result ports): one result per
// request, showing mode, line, compare flag and window line after the update,
// together with the scan, draw and frame pulses and the interrupt requests.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// the registers should be written only while no request is in flight.
// A request accepted into the input register moves on to the output register
// through the combinational mode update once the output register is free.
// Throughput: one request per cycle while results are taken; the input and
// output registers each hold one request, and the mode update is combinational.
// When the receiver stalls, the result holds on the output register and one
// more request waits in the input register before in_ready drops.
// Reset puts the block in OAM scan at line 0 with an empty accumulator and
// clears all configuration registers; no interrupt is raised for that mode.
module lcd_scanline_mode_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsmt_pkg::DOTS_W-1:0]   dots,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    mode,
	output logic [lsmt_pkg::LINE_W-1:0]   line,
	output logic                          line_match,
	output logic [lsmt_pkg::LINE_W-1:0]   window_line,
	output logic                          scan_start,
	output logic                          draw_start,
	output logic                          frame_ready,
	output logic                          vblank_irq,
	output logic                          status_irq,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [lsmt_pkg::CFG_W-1:0]    cfg_data
);

	lsmt_pkg::cfg_t                cfg_q;
	lsmt_pkg::state_t              state_q;
	lsmt_pkg::state_t              state_nxt;
	lsmt_pkg::pulse_t              pulse_nxt;
	lsmt_pkg::state_t              state_s2;
	lsmt_pkg::pulse_t              pulse_s2;
	logic                          valid_s1;
	logic [lsmt_pkg::DOTS_W-1:0]   dots_s1;
	logic                          valid_s2;
	logic                          advance;

	// The output register frees when empty or taken this cycle.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (lsmt_pkg::reg_index_t'(cfg_index))
				lsmt_pkg::REG_LINE_COMPARE: cfg_q.line_compare <= cfg_data;
				lsmt_pkg::REG_STAT_SELECT:  cfg_q.stat_select  <= cfg_data[3:0];
				lsmt_pkg::REG_WINDOW_ON:    cfg_q.window_on    <= cfg_data[0];
				lsmt_pkg::REG_WINDOW_Y:     cfg_q.window_y     <= cfg_data;
				lsmt_pkg::REG_WINDOW_X:     cfg_q.window_x     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register, with the count saturated on the way in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dots_s1 <= (dots > lsmt_pkg::DOTS_MAX) ? lsmt_pkg::DOTS_MAX : dots;
		end
	end

	lsmt_step u_step (
		.st    (state_q),
		.cfg   (cfg_q),
		.dots  (dots_s1),
		.nxt   (state_nxt),
		.pulse (pulse_nxt)
	);

	// Timer state advances as each request moves to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '{dot_accum: '0, cur_mode: lsmt_pkg::MODE_OAM, cur_line: '0,
				win_line: '0, match_flag: 1'b0};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			state_s2 <= state_nxt;
			pulse_s2 <= pulse_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign mode        = state_s2.cur_mode;
	assign line        = state_s2.cur_line;
	assign line_match  = state_s2.match_flag;
	assign window_line = state_s2.win_line;
	assign scan_start  = pulse_s2.scan_start;
	assign draw_start  = pulse_s2.draw_start;
	assign frame_ready = pulse_s2.frame_ready;
	assign vblank_irq  = pulse_s2.vblank_irq;
	assign status_irq  = pulse_s2.status_irq;

endmodule

// ===== rtl/lsmt_step.sv =====
module lsmt_step (
	input  lsmt_pkg::state_t               st,
	input  lsmt_pkg::cfg_t                 cfg,
	input  logic [lsmt_pkg::DOTS_W-1:0]    dots,
	output lsmt_pkg::state_t               nxt,
	output lsmt_pkg::pulse_t               pulse
);

	logic [lsmt_pkg::ACCUM_W-1:0] sum;
	logic [lsmt_pkg::LINE_W-1:0]  line_inc;
	logic                         line_eq;
	logic                         win_count;

	// The saturated count is at most 80 and the accumulator stays below 536,
	// so the sum never overflows ten bits.
	assign sum       = st.dot_accum + {{(lsmt_pkg::ACCUM_W-lsmt_pkg::DOTS_W){1'b0}}, dots};
	assign line_inc  = st.cur_line + 8'd1;
	assign line_eq   = (line_inc == cfg.line_compare);
	assign win_count = cfg.window_on && (st.cur_line >= cfg.window_y)
		&& (cfg.window_x <= lsmt_pkg::WINX_MAX);

	// One mode or line transition at most per request.
	always_comb begin
		nxt           = st;
		nxt.dot_accum = sum;
		pulse         = '0;
		case (st.cur_mode)
			lsmt_pkg::MODE_OAM: begin
				if (sum >= lsmt_pkg::OAM_DOTS) begin
					nxt.dot_accum    = sum - lsmt_pkg::OAM_DOTS;
					nxt.cur_mode     = lsmt_pkg::MODE_DRAW;
					pulse.scan_start = 1'b1;
				end
			end
			lsmt_pkg::MODE_DRAW: begin
				if (sum >= lsmt_pkg::DRAW_DOTS) begin
					nxt.dot_accum    = sum - lsmt_pkg::DRAW_DOTS;
					nxt.cur_mode     = lsmt_pkg::MODE_HBLANK;
					pulse.draw_start = 1'b1;
					pulse.status_irq = cfg.stat_select[lsmt_pkg::SEL_HBLANK];
				end
			end
			lsmt_pkg::MODE_HBLANK: begin
				if (sum >= lsmt_pkg::HBLANK_DOTS) begin
					nxt.dot_accum  = sum - lsmt_pkg::HBLANK_DOTS;
					if (win_count) begin
						nxt.win_line = st.win_line + 8'd1;
					end
					nxt.cur_line   = line_inc;
					nxt.match_flag = line_eq;
					if (line_inc == lsmt_pkg::VBLANK_LINE) begin
						nxt.cur_mode      = lsmt_pkg::MODE_VBLANK;
						pulse.frame_ready = 1'b1;
						pulse.vblank_irq  = 1'b1;
						pulse.status_irq  = (line_eq && cfg.stat_select[lsmt_pkg::SEL_MATCH])
							|| cfg.stat_select[lsmt_pkg::SEL_VBLANK];
					end else begin
						nxt.cur_mode     = lsmt_pkg::MODE_OAM;
						pulse.status_irq = (line_eq && cfg.stat_select[lsmt_pkg::SEL_MATCH])
							|| cfg.stat_select[lsmt_pkg::SEL_OAM];
					end
				end
			end
			lsmt_pkg::MODE_VBLANK: begin
				if (sum >= lsmt_pkg::LINE_DOTS) begin
					nxt.dot_accum    = sum - lsmt_pkg::LINE_DOTS;
					nxt.cur_line     = line_inc;
					nxt.match_flag   = line_eq;
					pulse.status_irq = line_eq && cfg.stat_select[lsmt_pkg::SEL_MATCH];
					// End of frame: wrap back to the first line.
					if (line_inc >= lsmt_pkg::FRAME_LINES) begin
						nxt.cur_line     = '0;
						nxt.win_line     = '0;
						nxt.cur_mode     = lsmt_pkg::MODE_OAM;
						pulse.status_irq = pulse.status_irq
							|| cfg.stat_select[lsmt_pkg::SEL_OAM];
					end
				end
			end
			default: begin
				nxt = st;
			end
		endcase
	end

endmodule

// ===== rtl/lsmt_checker.sv =====
module lsmt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  mode,
	input logic [lsmt_pkg::LINE_W-1:0] line,
	input logic                        scan_start,
	input logic                        draw_start,
	input logic                        frame_ready,
	input logic                        vblank_irq
);

	// A stalled result keeps its line and mode.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line) && $stable(mode))
		else $error("stalled result changed");

	// Frame completion lands on the first vertical blank line.
	a_frame_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ready |-> mode == lsmt_pkg::MODE_VBLANK
			&& line == lsmt_pkg::VBLANK_LINE && vblank_irq)
		else $error("frame_ready outside vblank entry");

	// The end-of-phase pulses match the mode that follows them.
	a_pulse_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (scan_start || draw_start) |->
			(scan_start && !draw_start && mode == lsmt_pkg::MODE_DRAW)
			|| (draw_start && !scan_start && mode == lsmt_pkg::MODE_HBLANK))
		else $error("pulse disagrees with mode");

	// Lines stay in range, and vblank only covers the lower lines.
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line < lsmt_pkg::FRAME_LINES
			&& ((mode == lsmt_pkg::MODE_VBLANK) == (line >= lsmt_pkg::VBLANK_LINE)))
		else $error("line out of range for mode");

endmodule

bind lcd_scanline_mode_timer lsmt_checker u_lsmt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.mode        (mode),
	.line        (line),
	.scan_start  (scan_start),
	.draw_start  (draw_start),
	.frame_ready (frame_ready),
	.vblank_irq  (vblank_irq)
);
